>>> hw/rtl/psq_pkg.sv
`timescale 1ns / 1ps

package psq_pkg;

  // Width of the counted-move step counter
  localparam int COUNT_WIDTH = 16;

  // Function codes of an input transaction
  localparam logic [2:0] FN_TICK     = 3'd0;
  localparam logic [2:0] FN_ENDSTOP  = 3'd1;
  localparam logic [2:0] FN_RUN_UP   = 3'd2;
  localparam logic [2:0] FN_RUN_DOWN = 3'd3;
  localparam logic [2:0] FN_STOP     = 3'd4;
  localparam logic [2:0] FN_MOVE     = 3'd5;

  // Configuration register indexes
  localparam int          CFG_IDX_W       = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 1'd1;

  localparam logic [7:0] STEP_PERIOD_RESET = 8'd31;

  typedef struct packed {
    logic       full_step;
    logic [7:0] step_period;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [1:0]         endstops;
    logic signed [15:0] step_count;
  } item_t;

  typedef struct packed {
    logic [3:0] coils;
    logic       running;
    logic       direction_up;
    logic       step_taken;
  } result_t;

  // One-hot coil select for a phase
  function automatic logic [3:0] coil_of(input logic [1:0] ph);
    coil_of = 4'b0001 << ph;
  endfunction

endpackage

>>> hw/rtl/psq_if.sv
`timescale 1ns / 1ps

// Command / tick input channel
interface psq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic [1:0]         endstops;
  logic signed [15:0] step_count;

  modport source (output valid, output func, output endstops, output step_count, input ready);
  modport sink   (input valid, input func, input endstops, input step_count, output ready);
endinterface

// Result channel
interface psq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] coils;
  logic       running;
  logic       direction_up;
  logic       step_taken;

  modport source (output valid, output coils, output running, output direction_up,
                  output step_taken, input ready);
  modport sink   (input valid, input coils, input running, input direction_up,
                  input step_taken, output ready);
endinterface

// Configuration write channel
interface psq_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/stepper_phase_sequencer_top.sv
`timescale 1ns / 1ps

// Four-coil stepper phase sequencer. Each input transaction (tick, endstop
// sample or command) yields exactly one result transaction carrying the coil
// pattern, run/direction status and whether a step was taken. One transaction
// is accepted every clock cycle unless the input stalls; its result passes
// through the input register, the state update and the result register
// before it is presented. The only limit on throughput is the result channel:
// the two registers form an elastic pipeline, so input stalls only when both
// stages hold data that the result sink has not yet taken. Configuration
// writes are always accepted and must only be issued while no
// transaction is in flight.
module stepper_phase_sequencer_top (
  input  logic      clk,
  input  logic      rst_n,
  psq_in_if.sink    in_ch,
  psq_out_if.source out_ch,
  psq_cfg_if.sink   cfg_ch
);

  psq_pkg::cfg_t    cfg;
  psq_pkg::item_t   in_pl_r;
  logic             in_valid_r;
  psq_pkg::result_t out_pl_r;
  psq_pkg::result_t core_res;
  logic             out_valid_r;
  logic             advance;
  logic             fire;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  psq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // Pipeline flow control
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && advance;
  assign in_ch.ready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_pl_r.func       <= in_ch.func;
      in_pl_r.endstops   <= in_ch.endstops;
      in_pl_r.step_count <= in_ch.step_count;
    end
  end

  // State update
  psq_step_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_pl_r),
    .cfg    (cfg),
    .result (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pl_r <= core_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coils        = out_pl_r.coils;
  assign out_ch.running      = out_pl_r.running;
  assign out_ch.direction_up = out_pl_r.direction_up;
  assign out_ch.step_taken   = out_pl_r.step_taken;

  // A step that leaves the motor running drives one or two coils
  a_step_coils: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pl_r.step_taken && out_pl_r.running
      |-> ($countones(out_pl_r.coils) == 1 || $countones(out_pl_r.coils) == 2))
    else $error("step left running motor with bad coil pattern");

  // A stop command de-energizes everything
  a_stop_off: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_pl_r.func == psq_pkg::FN_STOP
      |=> (out_pl_r.coils == 4'd0 && !out_pl_r.running && out_valid_r))
    else $error("stop did not clear coils and run");

  // A held input transaction stays held while the result stage is blocked
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_pl_r))
    else $error("input stage lost a transaction under backpressure");

  // Only a tick can report a step
  a_no_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_pl_r.func != psq_pkg::FN_TICK |=> !out_pl_r.step_taken)
    else $error("step reported for a non-tick transaction");

endmodule

>>> hw/rtl/psq_cfg_regs.sv
`timescale 1ns / 1ps

module psq_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [0:0]            wr_index,
  input  logic [7:0]            wr_data,
  output psq_pkg::cfg_t         cfg
);

  psq_pkg::cfg_t cfg_r;
  psq_pkg::cfg_t cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        psq_pkg::REG_FULL_STEP:   cfg_nxt.full_step   = wr_data[0];
        psq_pkg::REG_STEP_PERIOD: cfg_nxt.step_period = wr_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_step   <= 1'b0;
      cfg_r.step_period <= psq_pkg::STEP_PERIOD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/psq_step_core.sv
`timescale 1ns / 1ps

module psq_step_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  psq_pkg::item_t    item,
  input  psq_pkg::cfg_t     cfg,
  output psq_pkg::result_t  result
);

  localparam int CW    = psq_pkg::COUNT_WIDTH;
  localparam int SUM_W = (CW > 17) ? CW : 17;

  logic [1:0]    phase_r, phase_nxt;
  logic [3:0]    coil_r, coil_nxt;
  logic          run_r, run_nxt;
  logic          dir_up_r, dir_up_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [7:0]    tick_r, tick_nxt;
  logic [1:0]    hist_r, hist_nxt;

  logic          taken;
  logic [1:0]    phase_adv;
  logic [1:0]    changed;
  logic [16:0]   mag;
  logic [SUM_W-1:0] mag_inc;
  logic [SUM_W-1:0] cnt_max;
  logic [CW-1:0] move_load;
  logic [CW-1:0] steps_dec;

  // Phase move, magnitude of a counted move and its saturation
  assign phase_adv = dir_up_r ? (phase_r + 2'd1) : (phase_r - 2'd1);
  assign changed   = item.endstops ^ hist_r;
  assign mag       = item.step_count[15] ? (17'h10000 - {1'b0, item.step_count})
                                         : {1'b0, item.step_count};
  assign mag_inc   = SUM_W'(mag) + SUM_W'(1);
  assign cnt_max   = SUM_W'({CW{1'b1}});
  assign move_load = (mag_inc > cnt_max) ? CW'(cnt_max) : CW'(mag_inc);
  assign steps_dec = steps_r - CW'(1);

  // Next state for one transaction
  always_comb begin
    phase_nxt  = phase_r;
    coil_nxt   = coil_r;
    run_nxt    = run_r;
    dir_up_nxt = dir_up_r;
    steps_nxt  = steps_r;
    tick_nxt   = tick_r;
    hist_nxt   = hist_r;
    taken      = 1'b0;
    case (item.func)
      psq_pkg::FN_TICK: begin
        if (tick_r >= cfg.step_period) begin
          tick_nxt = 8'd0;
          if (run_r) begin
            taken     = 1'b1;
            phase_nxt = phase_adv;
            // full step drives the new phase and the next; wave drives the old phase
            if (cfg.full_step) begin
              coil_nxt = psq_pkg::coil_of(phase_adv) | psq_pkg::coil_of(phase_adv + 2'd1);
            end else begin
              coil_nxt = psq_pkg::coil_of(phase_r);
            end
            if (steps_r != '0) begin
              if (steps_dec <= CW'(1)) begin
                steps_nxt = '0;
                run_nxt   = 1'b0;
                coil_nxt  = 4'd0;
              end else begin
                steps_nxt = steps_dec;
              end
            end
          end
        end else begin
          tick_nxt = tick_r + 8'd1;
        end
      end
      psq_pkg::FN_ENDSTOP: begin
        hist_nxt = item.endstops;
        // endstop one has priority; endstop two only if one is unchanged
        if (changed[0]) begin
          if (!item.endstops[0]) begin
            dir_up_nxt = 1'b0;
            run_nxt    = 1'b1;
          end
        end else if (changed[1]) begin
          if (!item.endstops[1]) begin
            dir_up_nxt = 1'b1;
            run_nxt    = 1'b1;
          end
        end
      end
      psq_pkg::FN_RUN_UP: begin
        dir_up_nxt = 1'b1;
        run_nxt    = 1'b1;
      end
      psq_pkg::FN_RUN_DOWN: begin
        dir_up_nxt = 1'b0;
        run_nxt    = 1'b1;
      end
      psq_pkg::FN_STOP: begin
        run_nxt  = 1'b0;
        coil_nxt = 4'd0;
      end
      psq_pkg::FN_MOVE: begin
        if (item.step_count != 16'sd0) begin
          dir_up_nxt = !item.step_count[15];
          steps_nxt  = move_load;
          run_nxt    = 1'b1;
        end
      end
      default: begin
        taken = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 2'd0;
      coil_r   <= 4'd0;
      run_r    <= 1'b0;
      dir_up_r <= 1'b0;
      steps_r  <= '0;
      tick_r   <= 8'd0;
      hist_r   <= 2'b11;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      coil_r   <= coil_nxt;
      run_r    <= run_nxt;
      dir_up_r <= dir_up_nxt;
      steps_r  <= steps_nxt;
      tick_r   <= tick_nxt;
      hist_r   <= hist_nxt;
    end
  end

  // Result reflects the state after the update
  assign result.coils        = coil_nxt;
  assign result.running      = run_nxt;
  assign result.direction_up = dir_up_nxt;
  assign result.step_taken   = taken;

endmodule

>>> tb/sv/stepper_phase_sequencer_top_test.sv
`timescale 1ns / 1ps

// Unassigned function codes, accepted and ignored by the block
localparam logic [2:0] FN_SPARE_LO = 3'd6;
localparam logic [2:0] FN_SPARE_HI = 3'd7;

// Predicts the coil drive for every accepted transaction and checks results in order
class coil_drive_scoreboard;
  // register copies
  logic        full_mode;
  logic [7:0]  period;
  // sequencer state
  logic [1:0]  ph;
  logic [3:0]  coil_now;
  logic        run_on;
  logic        going_up;
  logic [15:0] moves_left;
  logic [7:0]  ticks;
  logic [1:0]  last_ends;
  bit          failed;
  psq_pkg::result_t expected_drive[$];

  function new();
    full_mode  = 1'b0;
    period     = psq_pkg::STEP_PERIOD_RESET;
    ph         = 2'd0;
    coil_now   = 4'd0;
    run_on     = 1'b0;
    going_up   = 1'b0;
    moves_left = 16'd0;
    ticks      = 8'd0;
    last_ends  = 2'b11;
    failed     = 1'b0;
  endfunction

  function void set_reg(logic [psq_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    if (idx == psq_pkg::REG_FULL_STEP) full_mode = val[0];
    else if (idx == psq_pkg::REG_STEP_PERIOD) period = val;
  endfunction

  function int pending();
    return expected_drive.size();
  endfunction

  // One motor step, including the end of a counted move
  function void take_step();
    if (full_mode) begin
      ph = going_up ? ph + 2'd1 : ph - 2'd1;
      coil_now = (4'b0001 << ph) | (4'b0001 << (ph + 2'd1));
    end else begin
      coil_now = 4'b0001 << ph;
      ph = going_up ? ph + 2'd1 : ph - 2'd1;
    end
    if (moves_left != 16'd0) begin
      moves_left = moves_left - 16'd1;
      if (moves_left <= 16'd1) begin
        moves_left = 16'd0;
        run_on     = 1'b0;
        coil_now   = 4'd0;
      end
    end
  endfunction

  // Accepted input transaction: update state, queue the expected result
  function void note_item(psq_pkg::item_t it);
    logic [1:0]  changed;
    logic [15:0] raw;
    int unsigned mag;
    psq_pkg::result_t res;
    res.step_taken = 1'b0;
    raw = it.step_count;
    case (it.func)
      psq_pkg::FN_TICK: begin
        if (ticks >= period) begin
          ticks = 8'd0;
          if (run_on) begin
            take_step();
            res.step_taken = 1'b1;
          end
        end else begin
          ticks = ticks + 8'd1;
        end
      end
      psq_pkg::FN_ENDSTOP: begin
        changed   = it.endstops ^ last_ends;
        last_ends = it.endstops;
        if (changed[0]) begin
          if (!it.endstops[0]) begin
            going_up = 1'b0;
            run_on   = 1'b1;
          end
        end else if (changed[1]) begin
          if (!it.endstops[1]) begin
            going_up = 1'b1;
            run_on   = 1'b1;
          end
        end
      end
      psq_pkg::FN_RUN_UP: begin
        going_up = 1'b1;
        run_on   = 1'b1;
      end
      psq_pkg::FN_RUN_DOWN: begin
        going_up = 1'b0;
        run_on   = 1'b1;
      end
      psq_pkg::FN_STOP: begin
        run_on   = 1'b0;
        coil_now = 4'd0;
      end
      psq_pkg::FN_MOVE: begin
        if (raw != 16'd0) begin
          if (raw[15]) begin
            going_up = 1'b0;
            mag = (32'h10000 - 32'(raw)) & 32'h1FFFF;
          end else begin
            going_up = 1'b1;
            mag = 32'(raw);
          end
          mag = mag + 1;
          moves_left = (mag > 32'hFFFF) ? 16'hFFFF : mag[15:0];
          run_on = 1'b1;
        end
      end
      default: ;
    endcase
    res.coils        = coil_now;
    res.running      = run_on;
    res.direction_up = going_up;
    expected_drive.push_back(res);
  endfunction

  // Accepted result transaction: compare with the oldest expectation
  function void check_result(psq_pkg::result_t got);
    psq_pkg::result_t want;
    if (expected_drive.size() == 0) begin
      $display("%0t: unexpected result coils=%h running=%b dir_up=%b step=%b",
               $time, got.coils, got.running, got.direction_up, got.step_taken);
      failed = 1'b1;
      return;
    end
    want = expected_drive.pop_front();
    if (got.coils !== want.coils) begin
      $display("%0t: coils expected %h actual %h", $time, want.coils, got.coils);
      failed = 1'b1;
    end
    if (got.running !== want.running) begin
      $display("%0t: running expected %b actual %b", $time, want.running, got.running);
      failed = 1'b1;
    end
    if (got.direction_up !== want.direction_up) begin
      $display("%0t: direction_up expected %b actual %b", $time, want.direction_up,
               got.direction_up);
      failed = 1'b1;
    end
    if (got.step_taken !== want.step_taken) begin
      $display("%0t: step_taken expected %b actual %b", $time, want.step_taken,
               got.step_taken);
      failed = 1'b1;
    end
  endfunction
endclass

module stepper_phase_sequencer_top_test;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 134;
  localparam int NUM_PHASES   = 6;

  logic clk;
  logic rst_n;

  psq_in_if  in_bus();
  psq_out_if out_bus();
  psq_cfg_if cfg_bus();

  stepper_phase_sequencer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  coil_drive_scoreboard board = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result sink: random backpressure
  always @(negedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    psq_pkg::result_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.coils        = out_bus.coils;
      got.running      = out_bus.running;
      got.direction_up = out_bus.direction_up;
      got.step_taken   = out_bus.step_taken;
      board.check_result(got);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic psq_pkg::item_t make_item(logic [2:0] fn, logic [1:0] ends, int cnt);
    psq_pkg::item_t it;
    it.func       = fn;
    it.endstops   = ends;
    it.step_count = cnt[15:0];
    return it;
  endfunction

  // Random command mix, mostly ticks and short counted moves
  function automatic psq_pkg::item_t random_item();
    psq_pkg::item_t it;
    int    r;
    int    cnt;
    r = $urandom_range(99);
    it.endstops   = 2'($urandom_range(3));
    it.step_count = 16'($urandom_range(16'hFFFF));
    if (r < 55) begin
      it.func = psq_pkg::FN_TICK;
    end else if (r < 68) begin
      it.func = psq_pkg::FN_ENDSTOP;
    end else if (r < 73) begin
      it.func = psq_pkg::FN_RUN_UP;
    end else if (r < 78) begin
      it.func = psq_pkg::FN_RUN_DOWN;
    end else if (r < 83) begin
      it.func = psq_pkg::FN_STOP;
    end else if (r < 96) begin
      it.func = psq_pkg::FN_MOVE;
      r = $urandom_range(99);
      if (r < 80) begin
        cnt = $urandom_range(1, 6);
        if ($urandom_range(1)) cnt = -cnt;
        it.step_count = cnt[15:0];
      end else if (r < 88) begin
        it.step_count = 16'sd0;
      end
      // otherwise keep the full random value
    end else begin
      it.func = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
    end
    return it;
  endfunction

  // Offer one input transaction; called and returns at a falling edge
  task automatic send_item(psq_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= it.func;
    in_bus.endstops   <= it.endstops;
    in_bus.step_count <= it.step_count;
    do @(posedge clk); while (!in_bus.ready);
    board.note_item(it);
    @(negedge clk);
  endtask

  // Hold off input until every result is back, then let the pipeline settle
  task automatic wait_drain();
    in_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // One register write; valid stays up so writes can follow back to back
  task automatic write_reg(logic [psq_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    board.set_reg(idx, val);
    @(negedge clk);
  endtask

  // Main sequence
  initial begin
    psq_pkg::item_t directed[$];
    logic [7:0]  periods[NUM_PHASES];
    logic [7:0]  fs_data;

    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = psq_pkg::FN_TICK;
    in_bus.endstops    = 2'b11;
    in_bus.step_count  = 16'sd0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = psq_pkg::REG_FULL_STEP;
    cfg_bus.data       = 8'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: wave mode, a step on every tick while running
    write_reg(psq_pkg::REG_FULL_STEP, 8'd0);
    write_reg(psq_pkg::REG_STEP_PERIOD, 8'd0);
    cfg_bus.valid <= 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;

    directed.push_back(make_item(psq_pkg::FN_TICK, 2'b11, 0));
    directed.push_back(make_item(psq_pkg::FN_RUN_UP, 2'b00, 0));
    directed.push_back(make_item(psq_pkg::FN_TICK, 2'b00, -1));
    directed.push_back(make_item(psq_pkg::FN_TICK, 2'b11, 32767));
    directed.push_back(make_item(psq_pkg::FN_RUN_DOWN, 2'b11, 0));
    directed.push_back(make_item(psq_pkg::FN_TICK, 2'b11, 0));
    directed.push_back(make_item(psq_pkg::FN_STOP, 2'b11, 0));
    // counted move of three, then an idle tick
    directed.push_back(make_item(psq_pkg::FN_MOVE, 2'b11, 3));
    repeat (4) directed.push_back(make_item(psq_pkg::FN_TICK, 2'b11, 0));
    // zero move is ignored
    directed.push_back(make_item(psq_pkg::FN_MOVE, 2'b11, 0));
    directed.push_back(make_item(psq_pkg::FN_MOVE, 2'b11, -32767));
    directed.push_back(make_item(psq_pkg::FN_TICK, 2'b11, 0));
    directed.push_back(make_item(psq_pkg::FN_STOP, 2'b11, 0));
    directed.push_back(make_item(psq_pkg::FN_MOVE, 2'b00, 32767));
    directed.push_back(make_item(psq_pkg::FN_STOP, 2'b11, 0));
    // endstop one falls, then endstop two alone, then both rise, then both fall
    directed.push_back(make_item(psq_pkg::FN_ENDSTOP, 2'b10, 0));
    directed.push_back(make_item(psq_pkg::FN_ENDSTOP, 2'b00, 0));
    directed.push_back(make_item(psq_pkg::FN_ENDSTOP, 2'b11, 0));
    directed.push_back(make_item(psq_pkg::FN_ENDSTOP, 2'b00, 0));
    directed.push_back(make_item(FN_SPARE_LO, 2'b01, -32768));
    directed.push_back(make_item(FN_SPARE_HI, 2'b10, 21845));
    directed.push_back(make_item(psq_pkg::FN_STOP, 2'b11, 0));

    foreach (directed[i]) send_item(directed[i]);

    // Random phases across register settings and idling profiles
    periods[0] = 8'd0;
    periods[1] = 8'd1;
    periods[2] = 8'd255;
    periods[3] = 8'd3;
    periods[4] = 8'd2;
    periods[5] = 8'($urandom_range(7));

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drain();
      fs_data = 8'($urandom_range(255));
      fs_data[0] = (p % 2 == 1);
      write_reg(psq_pkg::REG_FULL_STEP, fs_data);
      write_reg(psq_pkg::REG_STEP_PERIOD, periods[p]);
      cfg_bus.valid <= 1'b0;
      if (p < 2) begin
        send_idle_pct = 20;
        recv_idle_pct = 49;
      end else if (p < 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off mid-phase until the result queue is empty
        if (n == PHASE_ITEMS / 2) wait_drain();
        send_item(random_item());
      end
    end

    wait_drain();
    if (!board.failed && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
